FILE: design/brn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_pkg
// Shared types and constants of the bilinear resize and normalize unit.
// ----------------------------------------------------------------------------
package brn_pkg;

  localparam int DIM_W        = 13;
  localparam int COORD_W      = 12;
  localparam int FRAC_W       = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 17;
  localparam int RESULT_DEPTH = 8;
  localparam int CREDIT_W     = 4;
  localparam int CMD_DEPTH    = 4;

  localparam logic [FRAC_W:0] WEIGHT_ONE = 17'h10000;

  localparam logic [23:0] MEAN_Q16 [3] = '{24'd8105165, 24'd7620526, 24'd6784942};
  localparam logic [18:0] INV_STD_Q24 [3] = '{19'd287306, 19'd293719, 19'd292413};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_STEP_Q16      = 3'd2,
    REG_VALID_WIDTH   = 3'd3,
    REG_VALID_HEIGHT  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_STORE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    OP_STORE   = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_PAD     = 2'd2
  } op_t;

  typedef struct packed {
    logic       command;
    logic [9:0] pixel_col;
    logic [9:0] pixel_row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] out_col;
    logic [9:0] out_row;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] norm_red;
    logic signed [15:0] norm_green;
    logic signed [15:0] norm_blue;
    logic               padded;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
    logic [23:0]        rgb;
  } cmd_t;

endpackage

FILE: design/brn_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_fifo
// Small register queue with count, used between pipeline parts.
// ----------------------------------------------------------------------------
module brn_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);

  T               mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    count_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

FILE: design/brn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_front
// Accepts beats, holds configuration, classifies items and locates neighbors.
// ----------------------------------------------------------------------------
module brn_front import brn_pkg::*; #(
  parameter int OUT_SIZE       = 1024,
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  cmd_push,
  input  logic                  cmd_full,
  output cmd_t                  cmd
);

  typedef struct packed {
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
    logic [FRAC_W-1:0]  frac;
  } loc_t;

  logic [10:0]     src_w_r, src_h_r, valid_w_r, valid_h_r;
  logic [16:0]     step_r;
  logic            f_vld_r;
  op_t             f_op_r;
  logic [26:0]     f_sx_r, f_sy_r;
  logic [9:0]      f_col_r, f_row_r;
  logic [23:0]     f_rgb_r;
  logic            advance;
  logic            accept;
  logic            keep;
  op_t             op_nxt;
  logic [DIM_W-1:0] w_eff, h_eff;
  loc_t            lx, ly;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [10:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (DIM_W'(v) > maxv) r = maxv;
    else r = DIM_W'(v);
    return r;
  endfunction

  // Past the last interior index both neighbors collapse onto the edge pixel.
  function automatic loc_t locate(input logic [26:0] s, input logic [DIM_W-1:0] size);
    loc_t             l;
    logic [DIM_W-1:0] i;
    i = DIM_W'(s[26:16]);
    if (i >= size - 1'b1) begin
      l.a    = COORD_W'(size - 1'b1);
      l.b    = l.a;
      l.frac = '0;
    end else begin
      l.a    = COORD_W'(i);
      l.b    = COORD_W'(i + 1'b1);
      l.frac = s[15:0];
    end
    return l;
  endfunction

  assign advance = !f_vld_r || !cmd_full;
  assign in_full = !advance;
  assign accept  = in_push && advance;

  always_comb begin
    keep   = 1'b1;
    op_nxt = OP_STORE;
    if (in_item.command == CMD_STORE) begin
      keep = (DIM_W'(in_item.pixel_col) < DIM_W'(MAX_SRC_WIDTH)) &&
             (DIM_W'(in_item.pixel_row) < DIM_W'(MAX_SRC_HEIGHT));
    end else if ((DIM_W'(in_item.out_col) >= DIM_W'(valid_w_r)) ||
                 (DIM_W'(in_item.out_row) >= DIM_W'(valid_h_r)) ||
                 (DIM_W'(in_item.out_col) >= DIM_W'(OUT_SIZE)) ||
                 (DIM_W'(in_item.out_row) >= DIM_W'(OUT_SIZE))) begin
      op_nxt = OP_PAD;
    end else begin
      op_nxt = OP_COMPUTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r   <= 11'd1024;
      src_h_r   <= 11'd1024;
      step_r    <= 17'h10000;
      valid_w_r <= 11'd1024;
      valid_h_r <= 11'd1024;
      f_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:  src_w_r   <= cfg_wdata[10:0];
          REG_SOURCE_HEIGHT: src_h_r   <= cfg_wdata[10:0];
          REG_STEP_Q16:      step_r    <= cfg_wdata;
          REG_VALID_WIDTH:   valid_w_r <= cfg_wdata[10:0];
          REG_VALID_HEIGHT:  valid_h_r <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (advance) f_vld_r <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op_r  <= op_nxt;
      f_sx_r  <= 27'(in_item.out_col * step_r);
      f_sy_r  <= 27'(in_item.out_row * step_r);
      f_col_r <= in_item.pixel_col;
      f_row_r <= in_item.pixel_row;
      f_rgb_r <= {in_item.red, in_item.green, in_item.blue};
    end
  end

  assign w_eff = clamp_dim(src_w_r, DIM_W'(MAX_SRC_WIDTH));
  assign h_eff = clamp_dim(src_h_r, DIM_W'(MAX_SRC_HEIGHT));
  assign lx    = locate(f_sx_r, w_eff);
  assign ly    = locate(f_sy_r, h_eff);

  always_comb begin
    cmd.op  = f_op_r;
    cmd.rgb = f_rgb_r;
    if (f_op_r == OP_STORE) begin
      cmd.x0 = COORD_W'(f_col_r);
      cmd.x1 = COORD_W'(f_col_r);
      cmd.y0 = COORD_W'(f_row_r);
      cmd.y1 = COORD_W'(f_row_r);
      cmd.fx = '0;
      cmd.fy = '0;
    end else begin
      cmd.x0 = lx.a;
      cmd.x1 = lx.b;
      cmd.y0 = ly.a;
      cmd.y1 = ly.b;
      cmd.fx = lx.frac;
      cmd.fy = ly.frac;
    end
  end

  assign cmd_push = f_vld_r;

endmodule

FILE: design/brn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_back
// Frame store, neighbor read sequencer, blend and normalize pipeline.
// ----------------------------------------------------------------------------
module brn_back import brn_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  input  cmd_t      cmd,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam int XW      = $clog2(MAX_SRC_WIDTH);
  localparam int YW      = $clog2(MAX_SRC_HEIGHT);
  localparam int AW      = XW + YW;
  localparam int MDEPTH  = 1 << AW;

  typedef struct packed {
    logic              vld;
    logic              pad;
    logic [1:0]        ph;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } tag_t;

  logic [23:0]         mem [MDEPTH];
  cmd_t                cur_r, cur_nxt;
  logic                busy_r, busy_nxt;
  logic [1:0]          ph_r, ph_nxt;
  logic [CREDIT_W-1:0] outst_r;
  logic                start;
  logic                mem_we;
  cmd_t                src;
  tag_t                iss;
  logic [AW-1:0]       addr;
  logic [23:0]         rd_r;
  tag_t                t1_r, t2_r, t3_r, t4_r, t5_r, t6_r;
  logic [24:0]         hp_r [3];
  logic [24:0]         part_r [3];
  logic [24:0]         hs_r [3];
  logic [40:0]         vp_r [3];
  logic [40:0]         vtop_r [3];
  logic [40:0]         acc_r [3];
  logic signed [45:0]  p_r [3];
  logic [FRAC_W:0]     wx, wy;
  logic signed [15:0]  qsat [3];
  out_item_t           res;
  logic                o_full;
  logic                can_result;

  assign can_result = outst_r < CREDIT_W'(RESULT_DEPTH);

  // A compute item issues four consecutive frame store reads, one per neighbor.
  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    start    = 1'b0;
    mem_we   = 1'b0;
    cmd_pop  = 1'b0;
    src      = cmd;
    iss      = '0;
    if (busy_r) begin
      src      = cur_r;
      iss.vld  = 1'b1;
      iss.ph   = ph_r;
      ph_nxt   = ph_r + 1'b1;
      busy_nxt = (ph_r != 2'd3);
    end else if (!cmd_empty) begin
      case (cmd.op)
        OP_STORE: begin
          mem_we  = 1'b1;
          cmd_pop = 1'b1;
        end
        OP_COMPUTE: begin
          if (can_result) begin
            cmd_pop  = 1'b1;
            start    = 1'b1;
            iss.vld  = 1'b1;
            iss.ph   = 2'd0;
            cur_nxt  = cmd;
            busy_nxt = 1'b1;
            ph_nxt   = 2'd1;
          end
        end
        OP_PAD: begin
          if (can_result) begin
            cmd_pop = 1'b1;
            start   = 1'b1;
            iss.vld = 1'b1;
            iss.pad = 1'b1;
            iss.ph  = 2'd3;
          end
        end
        default: ;
      endcase
    end
    iss.fx = src.fx;
    iss.fy = src.fy;
    addr   = {(iss.ph[1] ? src.y1[YW-1:0] : src.y0[YW-1:0]),
              (iss.ph[0] ? src.x1[XW-1:0] : src.x0[XW-1:0])};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      ph_r    <= '0;
      outst_r <= '0;
      t1_r    <= '0;
      t2_r    <= '0;
      t3_r    <= '0;
      t4_r    <= '0;
      t5_r    <= '0;
      t6_r    <= '0;
    end else begin
      busy_r  <= busy_nxt;
      ph_r    <= ph_nxt;
      outst_r <= outst_r + CREDIT_W'(start) - CREDIT_W'(out_pop && !out_empty);
      t1_r    <= iss;
      t2_r    <= t1_r;
      t3_r    <= '{vld: t2_r.vld && t2_r.ph[0], pad: t2_r.pad, ph: t2_r.ph,
                   fx: t2_r.fx, fy: t2_r.fy};
      t4_r    <= t3_r;
      t5_r    <= '{vld: t4_r.vld && t4_r.ph[1], pad: t4_r.pad, ph: t4_r.ph,
                   fx: t4_r.fx, fy: t4_r.fy};
      t6_r    <= t5_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= src.rgb;
    rd_r <= mem[addr];
  end

  assign wx = t1_r.ph[0] ? {1'b0, t1_r.fx} : WEIGHT_ONE - {1'b0, t1_r.fx};
  assign wy = t3_r.ph[1] ? {1'b0, t3_r.fy} : WEIGHT_ONE - {1'b0, t3_r.fy};

  // Horizontal blend of each row's pixel pair, then vertical blend of the two rows.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      hp_r[c] <= 25'(rd_r[16-8*c +: 8] * wx);
      if (!t2_r.ph[0]) part_r[c] <= hp_r[c];
      else hs_r[c] <= part_r[c] + hp_r[c];
      vp_r[c] <= 41'(hs_r[c] * wy);
      if (!t4_r.ph[1]) vtop_r[c] <= vp_r[c];
      else acc_r[c] <= vtop_r[c] + vp_r[c];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic [41:0]        rnd;
      logic signed [25:0] d;
      rnd     = {1'b0, acc_r[c]} + 42'd32768;
      d       = $signed({1'b0, rnd[40:16]}) - $signed({2'b0, MEAN_Q16[c]});
      p_r[c] <= d * $signed({1'b0, INV_STD_Q24[c]});
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [45:0] qs;
      logic signed [17:0] q;
      qs = p_r[c] + 46'sd134217728;
      q  = qs[45:28];
      if (q > 18'sd32767) qsat[c] = 16'sh7fff;
      else if (q < -18'sd32768) qsat[c] = -16'sd32768;
      else qsat[c] = q[15:0];
    end
    if (t6_r.pad) begin
      res.norm_red   = '0;
      res.norm_green = '0;
      res.norm_blue  = '0;
      res.padded     = 1'b1;
    end else begin
      res.norm_red   = qsat[0];
      res.norm_green = qsat[1];
      res.norm_blue  = qsat[2];
      res.padded     = 1'b0;
    end
  end

  brn_fifo #(.T(out_item_t), .DEPTH(RESULT_DEPTH)) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (t6_r.vld),
    .din   (res),
    .full  (o_full),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r <= CREDIT_W'(RESULT_DEPTH))
    else $error("result credit count exceeds queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    t6_r.vld |-> !o_full)
    else $error("result arrives at a full result queue");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (!busy_r && !iss.vld))
    else $error("frame store write collides with a neighbor read");

  a_four_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ph_r == 2'd3) |=> !busy_r)
    else $error("compute item does not finish after four reads");

endmodule

FILE: design/bilinear_resize_normalize_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_resize_normalize_unit
// Stores RGB source pixels and returns bilinear resized, normalized pixels.
// Path: an accepted compute beat passes the front register, the command queue,
// four neighbor reads of the single-port frame store, then the blend and
// normalize registers. No new command is taken while those reads run.
// Reset: synchronous, clears control and sets registers to their reset values;
// the frame store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module bilinear_resize_normalize_unit import brn_pkg::*; #(
  parameter int OUT_SIZE       = 1024,
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  brn_front #(
    .OUT_SIZE       (OUT_SIZE),
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_push  (cmd_push),
    .cmd_full  (cmd_full),
    .cmd       (cmd_in)
  );

  brn_fifo #(.T(cmd_t), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  brn_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
